>>> rtl/tc6rx_pkg.sv
package tc6rx_pkg;

  // position within a chunk, 0 up to the largest chunk size inclusive
  localparam int unsigned POS_W = 7;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned CALC_W = 8;
  localparam int unsigned CMD_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_FOOTER    = 2'd1,
    OP_NO_BLOCKS = 2'd2,
    OP_XFER_FAIL = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_MORE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_SKIP    = 3'd2,
    ST_NOFRAME = 3'd3,
    ST_FAIL    = 3'd4,
    ST_DROP    = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       drop_flag;
    logic       data_valid;
    logic       frame_start;
    logic [3:0] start_word_offset;
    logic       frame_end;
    logic [5:0] last_byte_pos;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic             byte_valid;
    logic [2:0]       status;
    logic [LEN_W-1:0] frame_length;
    logic             last;
  } out_item_t;

  // one footer outcome: emit buffer range [from_pos, to_pos) with status and length
  typedef struct packed {
    logic [POS_W-1:0] from_pos;
    logic [POS_W-1:0] to_pos;
    logic [2:0]       status;
    logic [LEN_W-1:0] frame_length;
  } cmd_t;

  // buffer write from the front end
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } buf_wr_t;

  // read window still owed by the back end
  typedef struct packed {
    logic             busy;
    logic [POS_W-1:0] rd_pos;
    logic [POS_W-1:0] to_pos;
  } back_stat_t;

endpackage

>>> rtl/tc6rx_if.sv
interface tc6rx_in_if;
  logic                 valid;
  logic                 ready;
  tc6rx_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface tc6rx_out_if;
  logic                 valid;
  logic                 ready;
  tc6rx_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

>>> rtl/tc6_rx_chunk_reassembler.sv
// Receive chunk reassembler for a MAC-PHY serial data link.
// chunk_i carries one item per transaction: a payload byte of the current
// chunk, a chunk footer, or a no-blocks / transfer-fail event. frame_o carries
// the results: reassembled frame bytes, or one status-only result when an item
// emits no byte. Every item other than a payload byte yields at least one
// result, and the final one has last set.
// Payload bytes are taken one per cycle into the chunk buffer and give no
// result. A footer is classified combinationally and queued; the emitter loads it
// from the queue when idle and then sends one result per cycle while frame_o does
// not stall, so a footer passes the queue, the emitter load and the output register
// before its first result is presented, and the emitter stays busy until the last.
// The emitter reads the chunk buffer through a single read port.
// Payload bytes of the next chunk are held off only while they would overwrite
// a buffer entry not yet emitted, or while a footer waits in the queue; footers
// wait only when the two-entry queue is full.
// When frame_o stalls, the output register holds its result and the emitter
// waits; the front end keeps accepting footers until the queue fills, and bytes as above.
// Reset clears the chunk fill, the frame length, the queue and the output.
module tc6_rx_chunk_reassembler #(
  parameter int unsigned CHUNK_BYTES      = 64,
  parameter int unsigned WORD_OFFSET_UNIT = 4,
  parameter int unsigned END_OFFSET_ADD   = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tc6rx_in_if.sink    chunk_i,
  tc6rx_out_if.source frame_o
);
  import tc6rx_pkg::*;

  buf_wr_t    buf_wr;
  cmd_t       cmd_push_data;
  cmd_t       cmd_head;
  logic       cmd_push;
  logic       cmd_pop;
  logic       cmd_full;
  logic       cmd_empty;
  back_stat_t back_stat;

  // classification and buffer fill
  tc6rx_front #(
    .CHUNK_BYTES      (CHUNK_BYTES),
    .WORD_OFFSET_UNIT (WORD_OFFSET_UNIT),
    .END_OFFSET_ADD   (END_OFFSET_ADD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chunk_i     (chunk_i),
    .buf_wr_o    (buf_wr),
    .cmd_o       (cmd_push_data),
    .cmd_push_o  (cmd_push),
    .cmd_full_i  (cmd_full),
    .cmd_empty_i (cmd_empty),
    .back_i      (back_stat)
  );

  // command queue between the two halves
  tc6rx_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_push_data),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_head),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  // emitter with chunk buffer
  tc6rx_back #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .buf_wr_i    (buf_wr),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .stat_o      (back_stat),
    .frame_o     (frame_o)
  );

  // queue never written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  // a buffer write never lands inside the window still to be emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_wr.en |-> !(back_stat.busy && (buf_wr.pos >= back_stat.rd_pos) &&
                    (buf_wr.pos < back_stat.to_pos)))
    else $error("buffer write over unread entry");

  // no payload byte taken while a footer waits in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) buf_wr.en |-> cmd_empty)
    else $error("buffer written with footer pending");

  // emitter read window stays ordered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.busy |-> (back_stat.rd_pos <= back_stat.to_pos))
    else $error("read window inverted");

endmodule

>>> rtl/tc6rx_front.sv
module tc6rx_front #(
  parameter int unsigned CHUNK_BYTES      = 64,
  parameter int unsigned WORD_OFFSET_UNIT = 4,
  parameter int unsigned END_OFFSET_ADD   = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tc6rx_in_if.sink              chunk_i,
  output tc6rx_pkg::buf_wr_t    buf_wr_o,
  output tc6rx_pkg::cmd_t       cmd_o,
  output logic                  cmd_push_o,
  input  logic                  cmd_full_i,
  input  logic                  cmd_empty_i,
  input  tc6rx_pkg::back_stat_t back_i
);
  import tc6rx_pkg::*;

  localparam logic [POS_W-1:0]  ChunkPos  = POS_W'(CHUNK_BYTES);
  localparam logic [CALC_W-1:0] ChunkCalc = CALC_W'(CHUNK_BYTES);

  logic [POS_W-1:0] fill_q, fill_d;
  logic [LEN_W-1:0] frame_q, frame_d;

  logic             is_byte;
  logic             hazard;
  logic             accept;
  logic [CALC_W-1:0] start_calc, end_calc;
  logic [POS_W-1:0] from_pos, end_pos, to_pos, span;
  logic [LEN_W-1:0] base_len, sum_len;
  cmd_t             cmd;

  assign is_byte = (chunk_i.item.operation == OP_BYTE);

  // a new byte must not overwrite an entry the back end still has to emit
  assign hazard = !cmd_empty_i ||
                  (back_i.busy && (fill_q >= back_i.rd_pos) && (fill_q < back_i.to_pos));

  assign chunk_i.ready = is_byte ? !hazard : !cmd_full_i;
  assign accept        = chunk_i.valid && chunk_i.ready;

  // buffer write
  assign buf_wr_o.en   = accept && is_byte && (fill_q < ChunkPos);
  assign buf_wr_o.pos  = fill_q;
  assign buf_wr_o.data = chunk_i.item.data_byte;

  // footer positions, saturated at the chunk size
  always_comb begin
    start_calc = CALC_W'(chunk_i.item.start_word_offset) * CALC_W'(WORD_OFFSET_UNIT);
    end_calc   = CALC_W'(chunk_i.item.last_byte_pos) + CALC_W'(END_OFFSET_ADD);
    if (!chunk_i.item.frame_start) begin
      from_pos = '0;
    end else if (start_calc > ChunkCalc) begin
      from_pos = ChunkPos;
    end else begin
      from_pos = start_calc[POS_W-1:0];
    end
    if (!chunk_i.item.frame_end) begin
      end_pos = ChunkPos;
    end else if (end_calc > ChunkCalc) begin
      end_pos = ChunkPos;
    end else begin
      end_pos = end_calc[POS_W-1:0];
    end
    to_pos   = (end_pos < from_pos) ? from_pos : end_pos;
    span     = to_pos - from_pos;
    base_len = chunk_i.item.frame_start ? '0 : frame_q;
    sum_len  = base_len + LEN_W'(span);
  end

  // footer classification
  always_comb begin
    cmd     = '0;
    frame_d = frame_q;
    fill_d  = fill_q;
    case (chunk_i.item.operation)
      OP_FOOTER: begin
        fill_d = '0;
        if (chunk_i.item.drop_flag) begin
          cmd.status = ST_DROP;
          frame_d    = '0;
        end else if (!chunk_i.item.data_valid ||
                     ((frame_q == '0) && !chunk_i.item.frame_start)) begin
          cmd.status       = ST_SKIP;
          cmd.frame_length = frame_q;
        end else begin
          cmd.from_pos     = from_pos;
          cmd.to_pos       = to_pos;
          cmd.frame_length = sum_len;
          if (chunk_i.item.frame_end) begin
            cmd.status = ST_DONE;
            frame_d    = '0;
          end else begin
            cmd.status = ST_MORE;
            frame_d    = sum_len;
          end
        end
      end
      OP_NO_BLOCKS, OP_XFER_FAIL: begin
        fill_d     = '0;
        frame_d    = '0;
        cmd.status = (chunk_i.item.operation == OP_NO_BLOCKS) ? ST_NOFRAME : ST_FAIL;
      end
      default: begin
        if (fill_q < ChunkPos) begin
          fill_d = fill_q + POS_W'(1);
        end
      end
    endcase
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept && !is_byte;

  // chunk fill and running frame length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      frame_q <= '0;
    end else if (accept) begin
      fill_q  <= fill_d;
      frame_q <= frame_d;
    end
  end

endmodule

>>> rtl/tc6rx_cmd_fifo.sv
module tc6rx_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tc6rx_pkg::cmd_t cmd_i,
  input  logic            pop_i,
  output tc6rx_pkg::cmd_t cmd_o,
  output logic            full_o,
  output logic            empty_o
);
  import tc6rx_pkg::*;

  localparam int unsigned PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             slot_q [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/tc6rx_back.sv
module tc6rx_back #(
  parameter int unsigned CHUNK_BYTES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tc6rx_pkg::buf_wr_t    buf_wr_i,
  input  tc6rx_pkg::cmd_t       cmd_i,
  input  logic                  cmd_empty_i,
  output logic                  cmd_pop_o,
  output tc6rx_pkg::back_stat_t stat_o,
  tc6rx_out_if.source           frame_o
);
  import tc6rx_pkg::*;

  localparam int unsigned ADDR_W = $clog2(CHUNK_BYTES);

  logic [7:0]       buf_q [CHUNK_BYTES];

  logic             busy_q, busy_d;
  logic [POS_W-1:0] rd_pos_q, rd_pos_d;
  logic [POS_W-1:0] to_pos_q, to_pos_d;
  logic [2:0]       status_q, status_d;
  logic [LEN_W-1:0] len_q, len_d;

  logic             out_valid_q, out_valid_d;
  logic             out_bv_q, out_bv_d;
  logic             out_last_q, out_last_d;
  logic [2:0]       out_status_q, out_status_d;
  logic [LEN_W-1:0] out_len_q, out_len_d;
  logic [7:0]       out_byte_q;

  logic             out_free;
  logic             issue;
  logic             has_bytes;
  logic             load;

  assign out_free  = !out_valid_q || frame_o.ready;
  assign load      = !busy_q && !cmd_empty_i;
  assign issue     = busy_q && out_free;
  assign has_bytes = (rd_pos_q < to_pos_q);
  assign cmd_pop_o = load;

  assign stat_o.busy   = busy_q;
  assign stat_o.rd_pos = rd_pos_q;
  assign stat_o.to_pos = to_pos_q;

  // chunk buffer write port
  always_ff @(posedge clk_i) begin
    if (buf_wr_i.en) begin
      buf_q[buf_wr_i.pos[ADDR_W-1:0]] <= buf_wr_i.data;
    end
  end

  // chunk buffer read port, straight into the output register
  always_ff @(posedge clk_i) begin
    if (issue && has_bytes) begin
      out_byte_q <= buf_q[rd_pos_q[ADDR_W-1:0]];
    end
  end

  // command sequencing and output stage
  always_comb begin
    busy_d       = busy_q;
    rd_pos_d     = rd_pos_q;
    to_pos_d     = to_pos_q;
    status_d     = status_q;
    len_d        = len_q;
    out_valid_d  = out_valid_q;
    out_bv_d     = out_bv_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    out_len_d    = out_len_q;
    if (out_valid_q && frame_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d   = 1'b1;
      rd_pos_d = cmd_i.from_pos;
      to_pos_d = cmd_i.to_pos;
      status_d = cmd_i.status;
      len_d    = cmd_i.frame_length;
    end
    if (issue) begin
      out_valid_d  = 1'b1;
      out_bv_d     = has_bytes;
      out_status_d = status_q;
      out_len_d    = len_q;
      out_last_d   = !has_bytes || (rd_pos_q + POS_W'(1) == to_pos_q);
      if (has_bytes) begin
        rd_pos_d = rd_pos_q + POS_W'(1);
      end
      if (out_last_d) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rd_pos_q    <= '0;
      to_pos_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rd_pos_q    <= rd_pos_d;
      to_pos_q    <= to_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    len_q        <= len_d;
    out_bv_q     <= out_bv_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
    out_len_q    <= out_len_d;
  end

  assign frame_o.valid             = out_valid_q;
  assign frame_o.item.frame_byte   = out_bv_q ? out_byte_q : 8'd0;
  assign frame_o.item.byte_valid   = out_bv_q;
  assign frame_o.item.status       = out_status_q;
  assign frame_o.item.frame_length = out_len_q;
  assign frame_o.item.last         = out_last_q;

endmodule

>>> verif/tb.sv
module tb;
  import tc6rx_pkg::*;

  localparam int CHUNK_BYTES      = 64;
  localparam int WORD_OFFSET_UNIT = 4;
  localparam int END_OFFSET_ADD   = 1;
  localparam int RANDOM_ITEMS     = 340;
  localparam int STALL_LIMIT      = 1000;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PULSED,
    SINK_BLOCKY
  } sink_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  tc6rx_in_if  chunk_if ();
  tc6rx_out_if frame_if ();

  tc6_rx_chunk_reassembler #(
    .CHUNK_BYTES      (CHUNK_BYTES),
    .WORD_OFFSET_UNIT (WORD_OFFSET_UNIT),
    .END_OFFSET_ADD   (END_OFFSET_ADD)
  ) DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .chunk_i (chunk_if),
    .frame_o (frame_if)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pending chunk items and reassembled results still owed by the block
  in_item_t  chunk_items_q[$];
  out_item_t frame_results_q[$];

  // shadow copy of the reassembly state
  logic [7:0]  rx_buf [CHUNK_BYTES];
  int          buf_fill;
  logic [15:0] frame_len;

  bit in_taken;
  bit out_taken;
  int idle_cycles;
  int errors;
  int items_accepted;
  int results_checked;
  int bytes_checked;
  int frames_done;
  int frames_abandoned;

  // sender burst state
  int burst_left;
  int gap_left;

  // receiver stall pattern state
  sink_mode_e sink_mode;
  int         mode_left;
  int         pulse_period;
  int         pulse_cnt;
  int         stall_left;
  bit         rdy;

  // ---------------------------------------------------------------------------
  // reassembly prediction

  task automatic queue_results(input int from_pos, input int to_pos, input status_e st,
                               input logic [15:0] len);
    out_item_t r;
    r = '0;
    r.status       = st;
    r.frame_length = len;
    if (to_pos <= from_pos) begin
      r.last = 1'b1;
      frame_results_q.push_back(r);
    end else begin
      for (int i = from_pos; i < to_pos; i++) begin
        r.frame_byte = rx_buf[i];
        r.byte_valid = 1'b1;
        r.last       = (i == to_pos - 1);
        frame_results_q.push_back(r);
      end
    end
  endtask

  task automatic predict_reassembly(input in_item_t it);
    int          from_pos;
    int          to_pos;
    logic [15:0] len;
    case (it.operation)
      OP_BYTE: begin
        // bytes past the end of the chunk are dropped
        if (buf_fill < CHUNK_BYTES) begin
          rx_buf[buf_fill] = it.data_byte;
          buf_fill++;
        end
      end
      OP_NO_BLOCKS, OP_XFER_FAIL: begin
        buf_fill  = 0;
        frame_len = '0;
        queue_results(0, 0, (it.operation == OP_NO_BLOCKS) ? ST_NOFRAME : ST_FAIL, '0);
      end
      default: begin
        buf_fill = 0;
        if (it.drop_flag) begin
          frame_len = '0;
          queue_results(0, 0, ST_DROP, '0);
        end else if (!it.data_valid || (frame_len == '0 && !it.frame_start)) begin
          // invalid chunk, or no frame open and no start
          queue_results(0, 0, ST_SKIP, frame_len);
        end else begin
          if (it.frame_start) begin
            frame_len = '0;
            from_pos  = int'(it.start_word_offset) * WORD_OFFSET_UNIT;
            if (from_pos > CHUNK_BYTES) from_pos = CHUNK_BYTES;
          end else begin
            from_pos = 0;
          end
          if (it.frame_end) begin
            to_pos = int'(it.last_byte_pos) + END_OFFSET_ADD;
            if (to_pos > CHUNK_BYTES) to_pos = CHUNK_BYTES;
          end else begin
            to_pos = CHUNK_BYTES;
          end
          // end at or before start emits nothing
          if (to_pos < from_pos) to_pos = from_pos;
          len       = frame_len + 16'(to_pos - from_pos);
          frame_len = it.frame_end ? 16'd0 : len;
          queue_results(from_pos, to_pos, it.frame_end ? ST_DONE : ST_MORE, len);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building

  function automatic in_item_t noise_item();
    return in_item_t'(24'($urandom));
  endfunction

  task automatic push_byte(input logic [7:0] b);
    in_item_t it;
    it           = noise_item();
    it.operation = OP_BYTE;
    it.data_byte = b;
    chunk_items_q.push_back(it);
  endtask

  task automatic push_bytes(input int n);
    repeat (n) push_byte(8'($urandom));
  endtask

  task automatic push_footer(input bit drop, input bit dv, input bit sv, input int swo,
                             input bit ev, input int ebo);
    in_item_t it;
    it                   = noise_item();
    it.operation         = OP_FOOTER;
    it.drop_flag         = drop;
    it.data_valid        = dv;
    it.frame_start       = sv;
    it.start_word_offset = 4'(swo);
    it.frame_end         = ev;
    it.last_byte_pos     = 6'(ebo);
    chunk_items_q.push_back(it);
  endtask

  task automatic push_event(input op_e op);
    in_item_t it;
    it           = noise_item();
    it.operation = op;
    chunk_items_q.push_back(it);
  endtask

  // mostly short chunks, now and then a full or overfull one
  function automatic int chunk_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(0, 12);
    if (r < 19) return $urandom_range(13, 63);
    return $urandom_range(64, 66);
  endfunction

  task automatic push_random_footer();
    push_footer($urandom_range(0, 7) == 0, $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 63));
  endtask

  // well-formed start / middle / end sequence, occasionally broken mid-frame
  task automatic push_random_frame();
    bit one_chunk;
    int middles;
    push_bytes(chunk_len());
    one_chunk = ($urandom_range(0, 3) == 0);
    push_footer(0, 1, 1, $urandom_range(0, 15), one_chunk, $urandom_range(0, 63));
    if (!one_chunk) begin
      middles = $urandom_range(0, 2);
      repeat (middles) begin
        push_bytes(chunk_len());
        case ($urandom_range(0, 11))
          0:       push_footer(1, $urandom_range(0, 1), 0, 0, 0, 0);
          1:       push_footer(0, 0, $urandom_range(0, 1), 0, $urandom_range(0, 1), 0);
          2:       push_event($urandom_range(0, 1) ? OP_NO_BLOCKS : OP_XFER_FAIL);
          default: push_footer(0, 1, 0, $urandom_range(0, 15), 0, $urandom_range(0, 63));
        endcase
      end
      push_bytes(chunk_len());
      push_footer(0, 1, 0, $urandom_range(0, 15), 1, $urandom_range(0, 63));
    end
  endtask

  task automatic push_random_noise();
    case ($urandom_range(0, 5))
      0: push_event(OP_NO_BLOCKS);
      1: push_event(OP_XFER_FAIL);
      2: begin
        push_bytes(chunk_len());
        push_footer(1, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 15),
                    $urandom_range(0, 1), $urandom_range(0, 63));
      end
      default: begin
        push_bytes(chunk_len());
        push_random_footer();
      end
    endcase
  endtask

  task automatic build_directed();
    // fill every buffer entry, overrun the chunk, then skip it as invalid
    push_byte(8'h00);
    push_byte(8'hFF);
    push_bytes(CHUNK_BYTES);
    push_footer(0, 0, 1, 0, 1, 63);
    // drop, no blocks, transfer fail, no start with no frame open
    push_footer(1, 1, 1, 0, 1, 63);
    push_event(OP_NO_BLOCKS);
    push_event(OP_XFER_FAIL);
    push_footer(0, 1, 0, 15, 1, 0);
    // largest start offset, then an invalid chunk while the frame is open
    push_bytes(3);
    push_footer(0, 1, 1, 15, 0, 63);
    push_footer(0, 0, 0, 0, 0, 0);
    // restart the open frame, one middle, end on the last byte
    push_footer(0, 1, 1, 0, 0, 0);
    push_footer(0, 1, 0, 0, 0, 0);
    push_footer(0, 1, 0, 0, 1, 63);
    // end before start, single byte frame, start and end at the extremes
    push_footer(0, 1, 1, 2, 1, 3);
    push_footer(0, 1, 1, 0, 1, 0);
    push_footer(0, 1, 1, 15, 1, 63);
    // open frame abandoned by each kind of abort
    push_footer(0, 1, 1, 3, 0, 0);
    push_event(OP_XFER_FAIL);
    push_footer(0, 1, 1, 3, 0, 0);
    push_footer(1, 0, 0, 0, 0, 0);
    push_footer(0, 1, 1, 3, 0, 0);
    push_event(OP_NO_BLOCKS);
    push_footer(0, 1, 0, 0, 1, 5);
  endtask

  // ---------------------------------------------------------------------------
  // driver: chunk items in bursts with random gaps

  always @(negedge clk) begin
    if (!rst_n) begin
      chunk_if.valid <= 1'b0;
    end else if (!chunk_if.valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        chunk_if.valid <= 1'b0;
      end else if (chunk_items_q.size() != 0) begin
        chunk_if.valid <= 1'b1;
        chunk_if.item  <= chunk_items_q.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        chunk_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switching between modes
  always @(negedge clk) begin
    if (mode_left == 0) begin
      sink_mode    = sink_mode_e'($urandom_range(0, 3));
      mode_left    = $urandom_range(32, 256);
      pulse_period = $urandom_range(2, 5);
    end else begin
      mode_left--;
    end
    case (sink_mode)
      SINK_OPEN:   rdy = 1'b1;
      SINK_RANDOM: rdy = $urandom_range(0, 1);
      SINK_PULSED: begin
        pulse_cnt++;
        rdy = (pulse_cnt % pulse_period == 0);
      end
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 16);
        end
      end
    endcase
    frame_if.ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on accepted items, check accepted results, watchdog

  task automatic report_field(input string fname, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      in_taken  = chunk_if.valid && chunk_if.ready;
      out_taken = frame_if.valid && frame_if.ready;
      if (in_taken) begin
        items_accepted++;
        predict_reassembly(chunk_if.item);
      end
      if (out_taken) begin
        got = frame_if.item;
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %0d valid %0d status %0d length %0d last %0d",
                   $time, got.frame_byte, got.byte_valid, got.status, got.frame_length,
                   got.last);
          errors++;
        end else begin
          want = frame_results_q.pop_front();
          results_checked++;
          if (got.frame_byte !== want.frame_byte)
            report_field("frame_byte", want.frame_byte, got.frame_byte);
          if (got.byte_valid !== want.byte_valid)
            report_field("byte_valid", want.byte_valid, got.byte_valid);
          if (got.status !== want.status)
            report_field("status", want.status, got.status);
          if (got.frame_length !== want.frame_length)
            report_field("frame_length", want.frame_length, got.frame_length);
          if (got.last !== want.last)
            report_field("last", want.last, got.last);
          if (want.byte_valid) bytes_checked++;
          if (want.last && want.status == ST_DONE) frames_done++;
          if (want.last && (want.status == ST_DROP || want.status == ST_FAIL ||
                            want.status == ST_NOFRAME))
            frames_abandoned++;
        end
      end
      // no transaction on either side for too long
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, frame_results_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence

  initial begin
    int random_base;
    rst_n          = 1'b0;
    chunk_if.valid = 1'b0;
    chunk_if.item  = '0;
    frame_if.ready = 1'b0;
    buf_fill       = 0;
    frame_len      = '0;

    build_directed();
    random_base = chunk_items_q.size();
    while (chunk_items_q.size() - random_base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) push_random_frame();
      else push_random_noise();
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain
    while (chunk_items_q.size() != 0 || chunk_if.valid || frame_results_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (frame_results_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               frame_results_q.size());
      errors++;
    end

    $display("Sent %0d chunk items; checked %0d results carrying %0d frame bytes.",
             items_accepted, results_checked, bytes_checked);
    $display("Frames completed: %0d, abandoned: %0d.", frames_done, frames_abandoned);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
